FILE: rtl/core/swas_pkg.sv
// package: shared types, widths and constants of the sliding-window arq sender
package swas_pkg;

  localparam int FUNC_W       = 2;
  localparam int SEQ_FIELD_W  = 10;
  localparam int TOTAL_W      = 10;
  localparam int WIN_W        = 6;
  localparam int TIMEOUT_W    = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int RESULT_LIMIT = 64;
  localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

  localparam int MAX_FRAMES_DEF = 1024;
  localparam int TIME_BITS_DEF  = 32;

  localparam logic [TOTAL_W-1:0]   TOTAL_RST   = TOTAL_W'(1);
  localparam logic [WIN_W-1:0]     WIN_RST     = WIN_W'(50);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(1000);

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_ACK   = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACK_RD,
    ST_ACK_CHK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_RT_RD,
    ST_RT_CHK,
    ST_SEND,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic tick;
    logic rd_ack;
    logic wr_ack;
    logic lar_inc;
    logic load_retx;
    logic load_send;
    logic load_status;
  } swas_cmd_t;

  typedef struct packed {
    logic active;
    logic done;
    logic ack_ok;
    logic lar_lt_fs;
    logic rd_acked;
    logic rd_timed_out;
    logic can_send;
    logic can_send_next;
    logic out_free;
  } swas_stat_t;

endpackage

FILE: rtl/core/swas_in_if.sv
// interface: input item channel
interface swas_in_if;
  import swas_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FUNC_W-1:0]      func;
  logic [SEQ_FIELD_W-1:0] ack_seq;

  modport source (output valid, output func, output ack_seq, input ready);
  modport sink   (input valid, input func, input ack_seq, output ready);
endinterface

FILE: rtl/core/swas_out_if.sv
// interface: result channel
interface swas_out_if;
  import swas_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   frame_valid;
  logic [SEQ_FIELD_W-1:0] frame_seq;
  logic                   is_retransmit;
  logic                   done_res;
  logic                   last;

  modport source (output valid, output frame_valid, output frame_seq, output is_retransmit,
                  output done_res, output last, input ready);
  modport sink   (input valid, input frame_valid, input frame_seq, input is_retransmit,
                  input done_res, input last, output ready);
endinterface

FILE: rtl/core/swas_cfg_if.sv
// interface: configuration write channel
interface swas_cfg_if;
  import swas_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/swas_ram.sv
// generic simple dual-port ram with registered read
module swas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/swas_ctrl.sv
// controller: sequences start, tick and ack handling and result emission
module swas_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [swas_pkg::FUNC_W-1:0] in_func,
  output logic                      in_ready,
  input  swas_pkg::swas_stat_t      stat,
  output swas_pkg::swas_cmd_t       cmd
);
  import swas_pkg::*;

  state_t state_r, state_nxt;
  func_t  func;

  assign func = func_t'(in_func);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (func)
            FUNC_TICK: state_nxt = (stat.active && !stat.done) ? ST_RT_RD : ST_STATUS;
            FUNC_ACK:  state_nxt = ST_ACK_RD;
            default:   state_nxt = ST_STATUS;
          endcase
        end
      end
      ST_ACK_RD:   state_nxt = stat.ack_ok ? ST_ACK_CHK : ST_STATUS;
      ST_ACK_CHK:  state_nxt = stat.rd_timed_out ? ST_STATUS : ST_WALK_RD;
      ST_WALK_RD:  state_nxt = stat.lar_lt_fs ? ST_WALK_CHK : ST_STATUS;
      ST_WALK_CHK: state_nxt = stat.rd_acked ? ST_WALK_RD : ST_STATUS;
      ST_RT_RD:    state_nxt = stat.lar_lt_fs ? ST_RT_CHK : ST_SEND;
      ST_RT_CHK: begin
        if (stat.rd_acked || !stat.rd_timed_out) begin
          state_nxt = ST_SEND;
        end else if (stat.out_free) begin
          state_nxt = stat.can_send ? ST_SEND : ST_IDLE;
        end
      end
      ST_SEND: begin
        if (!stat.can_send) begin
          state_nxt = ST_STATUS;
        end else if (stat.out_free && !stat.can_send_next) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_STATUS: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        cmd.start  = in_valid && (func == FUNC_START);
        cmd.tick   = in_valid && (func == FUNC_TICK);
      end
      ST_ACK_RD:   cmd.rd_ack = 1'b1;
      ST_ACK_CHK:  cmd.wr_ack = !stat.rd_timed_out;
      ST_WALK_CHK: cmd.lar_inc = stat.rd_acked;
      ST_RT_CHK:   cmd.load_retx = !stat.rd_acked && stat.rd_timed_out && stat.out_free;
      ST_SEND:     cmd.load_send = stat.can_send && stat.out_free;
      ST_STATUS:   cmd.load_status = stat.out_free;
      default:     cmd = '0;
    endcase
  end
endmodule

FILE: rtl/core/swas_dp.sv
// datapath: config registers, window counters, frame table and result register
module swas_dp #(
  parameter int MAX_FRAMES = swas_pkg::MAX_FRAMES_DEF,
  parameter int TIME_BITS  = swas_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  swas_pkg::swas_cmd_t             cmd,
  output swas_pkg::swas_stat_t            stat,
  input  logic [swas_pkg::SEQ_FIELD_W-1:0] in_ack_seq,
  input  logic                            cfg_valid,
  input  logic [swas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swas_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_frame_valid,
  output logic [swas_pkg::SEQ_FIELD_W-1:0] out_frame_seq,
  output logic                            out_is_retransmit,
  output logic                            out_done_res,
  output logic                            out_last
);
  import swas_pkg::*;

  localparam int SEQ_W = $clog2(MAX_FRAMES);
  localparam int CMP_W = (SEQ_W > SEQ_FIELD_W) ? SEQ_W : SEQ_FIELD_W;
  localparam int TW    = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;
  localparam int ENT_W = TIME_BITS + 1;
  localparam logic [CMP_W-1:0] TOT_CAP = CMP_W'(MAX_FRAMES - 1);

  logic [TOTAL_W-1:0]   total_r;
  logic [WIN_W-1:0]     win_r;
  logic [TIMEOUT_W-1:0] timeout_r;

  logic                 active_r;
  logic [SEQ_W-1:0]     lar_r;
  logic [SEQ_W-1:0]     fs_r;
  logic [TIME_BITS-1:0] now_r;
  logic [CNT_W-1:0]     n_r;
  logic [SEQ_FIELD_W-1:0] ack_r;

  logic                   out_valid_r;
  logic                   out_frame_valid_r;
  logic [SEQ_FIELD_W-1:0] out_frame_seq_r;
  logic                   out_is_retransmit_r;
  logic                   out_done_res_r;
  logic                   out_last_r;

  logic [CMP_W-1:0]     lar_ext, fs_ext, tot, ack_ext, win_ext, diff, f_ext;
  logic [CMP_W:0]       diff_p1, fs_p1, tot_wide;
  logic [CNT_W-1:0]     n_p1;
  logic [TIME_BITS-1:0] rd_time, age;
  logic                 rd_acked;
  logic                 timed_out;
  logic                 out_free;

  logic                 ram_we;
  logic [SEQ_W-1:0]     ram_waddr, ram_raddr;
  logic [ENT_W-1:0]     ram_wdata, ram_rdata;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= TOTAL_RST;
      win_r     <= WIN_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TOTAL:   total_r   <= cfg_data[TOTAL_W-1:0];
        CFG_WINDOW:  win_r     <= cfg_data[WIN_W-1:0];
        CFG_TIMEOUT: timeout_r <= cfg_data[TIMEOUT_W-1:0];
        default:     total_r   <= total_r;
      endcase
    end
  end

  assign lar_ext  = CMP_W'(lar_r);
  assign fs_ext   = CMP_W'(fs_r);
  assign ack_ext  = CMP_W'(ack_r);
  assign win_ext  = CMP_W'(win_r);
  assign tot      = (CMP_W'(total_r) > TOT_CAP) ? TOT_CAP : CMP_W'(total_r);
  assign diff     = fs_ext - lar_ext;
  assign diff_p1  = {1'b0, diff} + (CMP_W + 1)'(1);
  assign fs_p1    = {1'b0, fs_ext} + (CMP_W + 1)'(1);
  assign tot_wide = {1'b0, tot};
  assign f_ext    = lar_ext + CMP_W'(1);
  assign n_p1     = n_r + CNT_W'(1);

  assign rd_acked  = ram_rdata[TIME_BITS];
  assign rd_time   = ram_rdata[TIME_BITS-1:0];
  assign age       = now_r - rd_time;
  assign timed_out = TW'(age) >= TW'(timeout_r);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    stat               = '0;
    stat.active        = active_r;
    stat.done          = active_r && (lar_ext >= tot);
    stat.ack_ok        = active_r && (ack_ext != '0) && (ack_ext <= fs_ext);
    stat.lar_lt_fs     = lar_r < fs_r;
    stat.rd_acked      = rd_acked;
    stat.rd_timed_out  = timed_out;
    stat.can_send      = (n_r < CNT_W'(RESULT_LIMIT)) && (fs_ext < tot) &&
                         (diff <= win_ext);
    stat.can_send_next = (n_p1 < CNT_W'(RESULT_LIMIT)) && (fs_p1 < tot_wide) &&
                         (diff_p1 <= {1'b0, win_ext});
    stat.out_free      = out_free;
  end

  // frame table: acked flag over send time
  always_comb begin
    ram_we    = cmd.wr_ack || cmd.load_retx || cmd.load_send;
    ram_raddr = cmd.rd_ack ? ack_ext[SEQ_W-1:0] : f_ext[SEQ_W-1:0];
    if (cmd.wr_ack) begin
      ram_waddr = ack_ext[SEQ_W-1:0];
      ram_wdata = {1'b1, rd_time};
    end else if (cmd.load_retx) begin
      ram_waddr = f_ext[SEQ_W-1:0];
      ram_wdata = {1'b0, now_r};
    end else begin
      ram_waddr = fs_p1[SEQ_W-1:0];
      ram_wdata = {1'b0, now_r};
    end
  end

  swas_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_FRAMES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      lar_r    <= '0;
      fs_r     <= '0;
      now_r    <= '0;
      n_r      <= '0;
    end else begin
      if (cmd.start) begin
        active_r <= 1'b1;
        lar_r    <= '0;
        fs_r     <= '0;
        now_r    <= '0;
      end
      if (cmd.tick) begin
        now_r <= now_r + TIME_BITS'(1);
      end
      if (cmd.accept) begin
        n_r <= '0;
      end else if (cmd.load_retx || cmd.load_send) begin
        n_r <= n_p1;
      end
      if (cmd.load_send) begin
        fs_r <= fs_p1[SEQ_W-1:0];
      end
      if (cmd.lar_inc) begin
        lar_r <= f_ext[SEQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ack_r <= in_ack_seq;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_retx || cmd.load_send || cmd.load_status) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_retx) begin
      out_frame_valid_r   <= 1'b1;
      out_frame_seq_r     <= f_ext[SEQ_FIELD_W-1:0];
      out_is_retransmit_r <= 1'b1;
      out_done_res_r      <= stat.done;
      out_last_r          <= !stat.can_send;
    end else if (cmd.load_send) begin
      out_frame_valid_r   <= 1'b1;
      out_frame_seq_r     <= fs_p1[SEQ_FIELD_W-1:0];
      out_is_retransmit_r <= 1'b0;
      out_done_res_r      <= stat.done;
      out_last_r          <= !stat.can_send_next;
    end else if (cmd.load_status) begin
      out_frame_valid_r   <= 1'b0;
      out_frame_seq_r     <= '0;
      out_is_retransmit_r <= 1'b0;
      out_done_res_r      <= stat.done;
      out_last_r          <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_valid   = out_frame_valid_r;
  assign out_frame_seq     = out_frame_seq_r;
  assign out_is_retransmit = out_is_retransmit_r;
  assign out_done_res      = out_done_res_r;
  assign out_last          = out_last_r;
endmodule

FILE: rtl/core/sliding_window_arq_sender.sv
// top level: sliding-window arq sender, controller plus datapath
//
//   channel | dir | handshake     | payload
//   in_if   | in  | valid / ready | func, ack_seq
//   out_if  | out | valid / ready | frame_valid, frame_seq, is_retransmit, done_res, last
//   cfg_if  | in  | valid / ready | index, data (ready always high)
//
// start, reserved, inactive or done-tick item: answered by its status result alone
// tick: may resend frame last-acked + 1, then send new frames (one frame-table read port)
// ack: status result if out of range or late, else mark acked and walk last-acked forward
// output register lets the next item in while a result waits; a held result stalls emission
// synchronous active-low reset; frame table needs no clearing, entries written at send
module sliding_window_arq_sender #(
  parameter int MAX_FRAMES = swas_pkg::MAX_FRAMES_DEF,
  parameter int TIME_BITS  = swas_pkg::TIME_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  swas_in_if.sink     in_if,
  swas_out_if.source  out_if,
  swas_cfg_if.sink    cfg_if
);
  import swas_pkg::*;

  swas_cmd_t  cmd;
  swas_stat_t stat;

  assign cfg_if.ready = 1'b1;

  swas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_func  (in_if.func),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swas_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_ack_seq        (in_if.ack_seq),
    .cfg_valid         (cfg_if.valid),
    .cfg_index         (cfg_if.index),
    .cfg_data          (cfg_if.data),
    .out_ready         (out_if.ready),
    .out_valid         (out_if.valid),
    .out_frame_valid   (out_if.frame_valid),
    .out_frame_seq     (out_if.frame_seq),
    .out_is_retransmit (out_if.is_retransmit),
    .out_done_res      (out_if.done_res),
    .out_last          (out_if.last)
  );
endmodule

FILE: rtl/core/swas_checker.sv
// checker: port-level assertions for the sliding-window arq sender, with bind
module swas_checker (
  input logic        clk,
  input logic        rst_n,
  swas_in_if.sink    in_if,
  swas_out_if.source out_if
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.frame_seq) &&
      $stable(out_if.last) && $stable(out_if.frame_valid))
    else $error("result changed while stalled");

  // input is not ready in the cycle after an item is taken
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("input taken on back-to-back cycles");

  // status result closes its item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.frame_valid |-> out_if.last && !out_if.is_retransmit &&
      (out_if.frame_seq == '0))
    else $error("malformed status result");

  // no frame goes out once the transfer is done
  a_send_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.frame_valid |-> !out_if.done_res && (out_if.frame_seq != '0))
    else $error("frame sent with transfer done");

endmodule

bind sliding_window_arq_sender swas_checker u_swas_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_if  (in_if),
  .out_if (out_if)
);

FILE: dv/tb_sliding_window_arq_sender.sv
// testbench: random and directed check of the sliding-window arq sender against a frame predictor
`timescale 1ns / 100ps

import swas_pkg::*;

typedef struct packed {
  logic                   frame_valid;
  logic [SEQ_FIELD_W-1:0] frame_seq;
  logic                   is_retransmit;
  logic                   done_res;
  logic                   last;
} frame_res_t;

class swas_scoreboard;
  frame_res_t                 frame_q[$];
  bit                         acked_map[MAX_FRAMES_DEF];
  logic [TIME_BITS_DEF-1:0]   send_time[MAX_FRAMES_DEF];
  logic [SEQ_FIELD_W-1:0]     last_acked;
  logic [SEQ_FIELD_W-1:0]     frames_sent;
  logic [TIME_BITS_DEF-1:0]   now_ticks;
  bit                         active;
  logic [TOTAL_W-1:0]         total_frames;
  logic [WIN_W-1:0]           window_size;
  logic [TIMEOUT_W-1:0]       timeout_ticks;
  int                         errors;

  function new();
    foreach (acked_map[i]) acked_map[i] = 1'b0;
    last_acked    = '0;
    frames_sent   = '0;
    now_ticks     = '0;
    active        = 1'b0;
    total_frames  = TOTAL_RST;
    window_size   = WIN_RST;
    timeout_ticks = TIMEOUT_RST;
    errors        = 0;
  endfunction

  task report(string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  function int pending();
    return frame_q.size();
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_TOTAL:   total_frames  = data[TOTAL_W-1:0];
      CFG_WINDOW:  window_size   = data[WIN_W-1:0];
      CFG_TIMEOUT: timeout_ticks = data[TIMEOUT_W-1:0];
      default: ;
    endcase
  endfunction

  function bit all_acked();
    return active && (last_acked >= total_frames);
  endfunction

  function bit aged_out(logic [SEQ_FIELD_W-1:0] seq);
    logic [TIME_BITS_DEF-1:0] age;
    age = now_ticks - send_time[seq];
    return age >= timeout_ticks;
  endfunction

  function void note_item(logic [FUNC_W-1:0] fn, logic [SEQ_FIELD_W-1:0] ack);
    frame_res_t             burst[$];
    logic [SEQ_FIELD_W-1:0] f;
    bit                     fin;
    case (fn)
      FUNC_START: begin
        foreach (acked_map[i]) acked_map[i] = 1'b0;
        last_acked  = '0;
        frames_sent = '0;
        now_ticks   = '0;
        active      = 1'b1;
      end
      FUNC_TICK: begin
        now_ticks = now_ticks + 1'b1;
        if (active && !all_acked()) begin
          f = last_acked + 1'b1;
          if (f <= frames_sent && !acked_map[f] && aged_out(f)) begin
            burst.push_back('{1'b1, f, 1'b1, 1'b0, 1'b0});
            send_time[f] = now_ticks;
          end
          while (burst.size() < RESULT_LIMIT && frames_sent < total_frames &&
                 (int'(frames_sent) - int'(last_acked)) <= int'(window_size)) begin
            frames_sent = frames_sent + 1'b1;
            send_time[frames_sent] = now_ticks;
            burst.push_back('{1'b1, frames_sent, 1'b0, 1'b0, 1'b0});
          end
        end
      end
      FUNC_ACK: begin
        if (active && ack >= 1 && ack <= frames_sent && !aged_out(ack)) begin
          acked_map[ack] = 1'b1;
          while (last_acked < frames_sent && acked_map[last_acked + 1'b1])
            last_acked = last_acked + 1'b1;
        end
      end
      default: ;
    endcase
    if (burst.size() == 0) burst.push_back('{1'b0, '0, 1'b0, 1'b0, 1'b0});
    fin = all_acked();
    foreach (burst[k]) begin
      burst[k].done_res = fin;
      burst[k].last     = (k == burst.size() - 1);
      frame_q.push_back(burst[k]);
    end
  endfunction

  task check_result(frame_res_t got);
    frame_res_t want;
    if (frame_q.size() == 0) begin
      report($sformatf("result with nothing pending, frame_seq %0d", got.frame_seq));
      return;
    end
    want = frame_q.pop_front();
    if (got.frame_valid !== want.frame_valid)
      report($sformatf("frame_valid %b, want %b", got.frame_valid, want.frame_valid));
    if (got.frame_seq !== want.frame_seq)
      report($sformatf("frame_seq %0d, want %0d", got.frame_seq, want.frame_seq));
    if (got.is_retransmit !== want.is_retransmit)
      report($sformatf("is_retransmit %b, want %b", got.is_retransmit, want.is_retransmit));
    if (got.done_res !== want.done_res)
      report($sformatf("done_res %b, want %b", got.done_res, want.done_res));
    if (got.last !== want.last)
      report($sformatf("last %b, want %b", got.last, want.last));
  endtask
endclass

module tb_sliding_window_arq_sender;
  localparam logic [FUNC_W-1:0]    FUNC_RSVD       = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RSVD        = 2'd3;
  localparam int                   CYCLE_LIMIT     = 1000000;
  localparam int                   HOLDOFF_CYCLES  = 400;
  localparam int                   SETTLE_CYCLES   = 16;
  localparam int                   PHASES          = 8;
  localparam int                   ITEMS_PER_PHASE = 50;

  logic clk = 1'b0;
  logic rst_n;
  logic holdoff_go;
  int   idle_pct = 0;
  int   stall_pct = 0;

  swas_scoreboard sb = new();

  swas_in_if  in_ch ();
  swas_out_if out_ch ();
  swas_cfg_if cfg_ch ();

  sliding_window_arq_sender u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #1 clk = ~clk;

  task automatic send_item(logic [FUNC_W-1:0] f, logic [SEQ_FIELD_W-1:0] a);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= f;
    in_ch.ack_seq <= a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(f, a);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SEQ_FIELD_W-1:0] pick_ack();
    int r;
    int fs;
    int la;
    r  = $urandom_range(99);
    fs = int'(sb.frames_sent);
    la = int'(sb.last_acked);
    if (r < 65 && fs > la) return SEQ_FIELD_W'($urandom_range(fs, la + 1));
    if (r < 80 && fs != 0) return SEQ_FIELD_W'($urandom_range(fs, 1));
    if (r < 85) return '0;
    if (r < 92 && fs < 1023) return SEQ_FIELD_W'(fs + 1);
    return SEQ_FIELD_W'($urandom);
  endfunction

  task automatic pick_item(output logic [FUNC_W-1:0] f, output logic [SEQ_FIELD_W-1:0] a);
    int r;
    r = $urandom_range(99);
    a = SEQ_FIELD_W'($urandom);
    if (!sb.active || r < 2) f = FUNC_START;
    else if (r < 5) f = FUNC_RSVD;
    else if (r < 50) f = FUNC_TICK;
    else begin
      f = FUNC_ACK;
      a = pick_ack();
    end
  endtask

  // result side: checks each transfer, stalls at random or for a long hold-off
  initial begin
    int         holdoff_left;
    frame_res_t got;
    holdoff_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.frame_valid   = out_ch.frame_valid;
        got.frame_seq     = out_ch.frame_seq;
        got.is_retransmit = out_ch.is_retransmit;
        got.done_res      = out_ch.done_res;
        got.last          = out_ch.last;
        sb.check_result(got);
      end
      if (holdoff_go) holdoff_left = HOLDOFF_CYCLES;
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_sliding_window_arq_sender: FAIL");
    $finish;
  end

  initial begin
    logic [FUNC_W-1:0]      f;
    logic [SEQ_FIELD_W-1:0] a;
    logic [TOTAL_W-1:0]     tot;
    logic [WIN_W-1:0]       win;
    logic [TIMEOUT_W-1:0]   tmo;
    bit                     restart;

    rst_n          <= 1'b0;
    holdoff_go     <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= FUNC_START;
    in_ch.ack_seq  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= CFG_TOTAL;
    cfg_ch.data    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // inactive block, then a one-frame transfer at reset settings
    send_item(FUNC_TICK, 10'h3FF);
    send_item(FUNC_ACK, 10'h3FF);
    send_item(FUNC_RSVD, 10'h155);
    send_item(FUNC_START, '0);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_ACK, 10'd0);
    send_item(FUNC_ACK, 10'd2);
    send_item(FUNC_ACK, 10'd1);
    send_item(FUNC_TICK, 10'h2AA);
    drain();

    // largest total, widest window, longest timeout: burst limit
    write_reg(CFG_TOTAL, 32'hFFFF_FFFF);
    write_reg(CFG_WINDOW, 32'hFFFF_FFFF);
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(CFG_RSVD, $urandom);
    send_item(FUNC_START, 10'h3FF);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_ACK, 10'd1);
    send_item(FUNC_ACK, 10'd1023);
    send_item(FUNC_TICK, '0);
    drain();

    // zero registers
    write_reg(CFG_TOTAL, 32'hFFFF_FC00);
    write_reg(CFG_WINDOW, 32'hFFFF_FFC0);
    write_reg(CFG_TIMEOUT, 32'h0);
    send_item(FUNC_START, '0);
    send_item(FUNC_TICK, '0);
    drain();
    write_reg(CFG_TOTAL, 32'd3);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_ACK, 10'd1);
    drain();

    // out of order acks, then total lowered mid-transfer
    write_reg(CFG_TOTAL, 32'd4);
    write_reg(CFG_WINDOW, 32'd2);
    write_reg(CFG_TIMEOUT, 32'd3);
    send_item(FUNC_START, '0);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_ACK, 10'd2);
    send_item(FUNC_ACK, 10'd1);
    drain();
    write_reg(CFG_TOTAL, 32'd2);
    send_item(FUNC_TICK, '0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      restart = (ph == 0) || ($urandom_range(99) < 80);
      if (restart) begin
        case ($urandom_range(9))
          0:       tot = '0;
          1:       tot = 10'd1023;
          2:       tot = 10'd1;
          default: tot = TOTAL_W'($urandom_range(48, 2));
        endcase
        case ($urandom_range(7))
          0:       win = '0;
          1:       win = 6'd63;
          2:       win = 6'd62;
          default: win = WIN_W'($urandom_range(8, 1));
        endcase
        case ($urandom_range(9))
          0:       tmo = '0;
          1:       tmo = 32'hFFFF_FFFF;
          2:       tmo = $urandom;
          default: tmo = TIMEOUT_W'($urandom_range(14, 1));
        endcase
        write_reg(CFG_TOTAL, ($urandom & ~32'h3FF) | 32'(tot));
        write_reg(CFG_WINDOW, ($urandom & ~32'h3F) | 32'(win));
        write_reg(CFG_TIMEOUT, tmo);
      end else begin
        // change the total under a running transfer
        write_reg(CFG_TOTAL, 32'($urandom_range(int'(sb.frames_sent) + 2, 0)));
      end
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      if (restart) send_item(FUNC_START, SEQ_FIELD_W'($urandom));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 4 && i == 10) begin
          in_ch.valid <= 1'b0;
          holdoff_go  <= 1'b1;
          @(posedge clk);
          holdoff_go  <= 1'b0;
        end
        pick_item(f, a);
        send_item(f, a);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_sliding_window_arq_sender: PASS");
    end else begin
      $display("tb_sliding_window_arq_sender: FAIL");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/swas_pkg.sv
rtl/core/swas_in_if.sv
rtl/core/swas_out_if.sv
rtl/core/swas_cfg_if.sv
rtl/core/swas_ram.sv
rtl/core/swas_ctrl.sv
rtl/core/swas_dp.sv
rtl/core/sliding_window_arq_sender.sv
rtl/core/swas_checker.sv
dv/tb_sliding_window_arq_sender.sv
